/* design/pt2r_pkg.sv */
// Shared types and constants for the planar 2bpp tile to raster converter.
package pt2r_pkg;

  // Photo geometry defaults, in tiles
  localparam int unsigned TILES_ACROSS_DEF = 16;
  localparam int unsigned TILES_DOWN_DEF   = 14;

  // Fixed geometry of one tile and of the stream fields
  localparam int unsigned TILE_SIDE   = 8;
  localparam int unsigned ROW_W       = 3;   // row within a tile
  localparam int unsigned TILE_CNT_W  = 5;   // tile column / tile row counters, up to 32
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned INDEX_W     = 14;
  localparam int unsigned SHADE_W     = 2;
  localparam int unsigned OUT_DATA_W  = 16;  // pixel_index + shade, byte aligned

  // Depth of the row job queue between front and back
  localparam int unsigned JOB_DEPTH   = 2;

  // One tile row handed from the byte front end to the pixel back end
  typedef struct packed {
    logic [BYTE_W-1:0]  low_plane;
    logic [BYTE_W-1:0]  high_plane;
    logic [INDEX_W-1:0] base_index;  // raster index of the leftmost pixel
    logic               last_tile;   // this row closes the photo when it is row 7
    logic               last_row;    // row 7 of its tile
  } row_job_t;

endpackage

/* design/pt2r_front.sv */
// Byte front end: tracks plane phase and tile position, queues one job per tile row.
module pt2r_front
  import pt2r_pkg::*;
#(
  parameter int unsigned TILES_ACROSS = TILES_ACROSS_DEF,
  parameter int unsigned TILES_DOWN   = TILES_DOWN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_start_i,
  output logic              in_ready_o,
  output logic              job_push_o,
  output row_job_t          job_o,
  input  logic              job_full_i
);

  localparam int unsigned WIDTH_PX = TILES_ACROSS * TILE_SIDE;
  localparam int unsigned ROWPX_W  = TILE_CNT_W + ROW_W;
  localparam int unsigned PROD_W   = ROWPX_W + $clog2(WIDTH_PX + 1);
  localparam int unsigned FULL_W   = (PROD_W > INDEX_W) ? PROD_W + 1 : INDEX_W + 1;

  logic [BYTE_W-1:0]     low_q, low_d;
  logic                  phase_q, phase_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [TILE_CNT_W-1:0] tx_q, tx_d;
  logic [TILE_CNT_W-1:0] ty_q, ty_d;

  logic                  accept;
  logic                  phase_eff;
  logic [ROW_W-1:0]      row_eff;
  logic [TILE_CNT_W-1:0] tx_eff, ty_eff;
  logic                  last_col, last_trow, last_row;
  logic [ROWPX_W-1:0]    row_px;
  logic [FULL_W-1:0]     index_full;

  assign in_ready_o = !job_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Start flag clears position and phase before the byte is taken
  assign phase_eff = in_start_i ? 1'b0 : phase_q;
  assign row_eff   = in_start_i ? '0 : row_q;
  assign tx_eff    = in_start_i ? '0 : tx_q;
  assign ty_eff    = in_start_i ? '0 : ty_q;

  assign last_col  = (tx_eff == TILE_CNT_W'(TILES_ACROSS - 1));
  assign last_trow = (ty_eff == TILE_CNT_W'(TILES_DOWN - 1));
  assign last_row  = (row_eff == ROW_W'(TILE_SIDE - 1));

  // Raster index of the row's first pixel
  assign row_px     = {ty_eff, {ROW_W{1'b0}}} + ROWPX_W'(row_eff);
  assign index_full = FULL_W'(row_px) * FULL_W'(WIDTH_PX)
                    + FULL_W'({tx_eff, {ROW_W{1'b0}}});

  always_comb begin
    job_o.low_plane  = low_q;
    job_o.high_plane = in_byte_i;
    job_o.base_index = index_full[INDEX_W-1:0];
    job_o.last_tile  = last_col && last_trow;
    job_o.last_row   = last_row;
  end

  assign job_push_o = accept && phase_eff;

  // Next state of phase and tile position
  always_comb begin
    low_d   = low_q;
    phase_d = phase_q;
    row_d   = row_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    if (accept) begin
      row_d = row_eff;
      tx_d  = tx_eff;
      ty_d  = ty_eff;
      if (!phase_eff) begin
        low_d   = in_byte_i;
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (last_row) begin
          row_d = '0;
          if (last_col) begin
            tx_d = '0;
            ty_d = last_trow ? '0 : ty_eff + 1'b1;
          end else begin
            tx_d = tx_eff + 1'b1;
          end
        end else begin
          row_d = row_eff + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= '0;
      phase_q <= 1'b0;
      row_q   <= '0;
      tx_q    <= '0;
      ty_q    <= '0;
    end else begin
      low_q   <= low_d;
      phase_q <= phase_d;
      row_q   <= row_d;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
    end
  end

endmodule

/* design/pt2r_fifo.sv */
// Short queue of tile row jobs between the front end and the pixel back end.
module pt2r_fifo
  import pt2r_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  row_job_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output row_job_t pop_data_o
);

  localparam int unsigned PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(JOB_DEPTH + 1);

  row_job_t          mem_q [JOB_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(JOB_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count update, pointers wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/pt2r_back.sv */
// Pixel back end: expands one tile row job into eight pixels behind an output register.
module pt2r_back
  import pt2r_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  row_job_t              job_i,
  output logic                  job_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [INDEX_W-1:0]    out_index_o,
  output logic [SHADE_W-1:0]    out_shade_o,
  output logic                  out_row_done_o,
  output logic                  out_photo_done_o
);

  localparam int unsigned PIX_W = $clog2(TILE_SIDE);

  row_job_t             job_q, job_d;
  logic                 busy_q, busy_d;
  logic [PIX_W-1:0]     pix_q, pix_d;
  logic                 ov_q, ov_d;
  logic [INDEX_W-1:0]   idx_q, idx_d;
  logic [SHADE_W-1:0]   shade_q, shade_d;
  logic                 rdone_q, rdone_d;
  logic                 pdone_q, pdone_d;

  logic                 advance, last_pix, load;
  logic [PIX_W-1:0]     bit_sel;
  logic [SHADE_W-1:0]   plane_val;

  assign advance  = busy_q && (!ov_q || out_ready_i);
  assign last_pix = (pix_q == PIX_W'(TILE_SIDE - 1));
  assign load     = job_valid_i && (!busy_q || (advance && last_pix));
  assign job_pop_o = load;

  // Leftmost pixel is bit 7
  assign bit_sel   = PIX_W'(TILE_SIDE - 1) - pix_q;
  assign plane_val = {job_q.high_plane[bit_sel], job_q.low_plane[bit_sel]};

  always_comb begin
    job_d   = job_q;
    busy_d  = busy_q;
    pix_d   = pix_q;
    ov_d    = ov_q;
    idx_d   = idx_q;
    shade_d = shade_q;
    rdone_d = rdone_q;
    pdone_d = pdone_q;
    // Drain the output register
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    // Produce the next pixel
    if (advance) begin
      ov_d    = 1'b1;
      idx_d   = job_q.base_index + INDEX_W'(pix_q);
      shade_d = ~plane_val;
      rdone_d = last_pix;
      pdone_d = last_pix && job_q.last_tile && job_q.last_row;
      pix_d   = pix_q + 1'b1;
      if (last_pix) begin
        busy_d = 1'b0;
      end
    end
    // Take the next row job
    if (load) begin
      job_d  = job_i;
      busy_d = 1'b1;
      pix_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pix_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pix_q  <= pix_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    idx_q   <= idx_d;
    shade_q <= shade_d;
    rdone_q <= rdone_d;
    pdone_q <= pdone_d;
  end

  assign out_valid_o      = ov_q;
  assign out_index_o      = idx_q;
  assign out_shade_o      = shade_q;
  assign out_row_done_o   = rdone_q;
  assign out_photo_done_o = pdone_q;

endmodule

/* design/planar_2bpp_tile_to_raster.sv */
// Top level of the planar 2bpp tile to raster converter.
//
// Input stream: one tile byte per transfer, low plane then high plane for each
// tile row; tuser set marks the first byte of a photo and clears the tile,
// row and phase counters before that byte is taken.
// Output stream: one pixel per transfer, eight per high-plane byte, leftmost
// first. tdata carries the raster index and the inverted shade, tlast marks
// the eighth pixel of a tile row, tuser the final pixel of the photo.
// With the back end idle, a row's high byte goes through the row job queue
// and the job register before its first pixel reaches the output register.
// Throughput: the pixel back end emits one pixel per cycle while tready stays
// high, eight per tile row of two bytes. Low bytes wait in the front end and
// bursts of up to two rows are absorbed by the two-entry row job queue.
// Reset clears the phase and counters, empties the queue and drops the
// output valid. When the receiver stalls, the output register holds its
// pixel, the back end stops, the queue fills and tready falls on the input.
// The counters wrap to the first tile after the last tile of the photo.
module planar_2bpp_tile_to_raster
  import pt2r_pkg::*;
#(
  parameter int unsigned TILES_ACROSS = TILES_ACROSS_DEF,
  parameter int unsigned TILES_DOWN   = TILES_DOWN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [BYTE_W-1:0]     s_axis_tdata_i,   // [7:0] tile_byte
  input  logic                  s_axis_tuser_i,   // [0] photo_start
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [13:0] pixel_index, [15:14] shade
  output logic                  m_axis_tlast_o,   // row_done
  output logic                  m_axis_tuser_o    // [0] photo_done
);

  row_job_t push_job, pop_job;
  logic     job_push, job_full, job_pop, job_valid;
  logic [INDEX_W-1:0] pix_index;
  logic [SHADE_W-1:0] pix_shade;

  pt2r_front #(
    .TILES_ACROSS (TILES_ACROSS),
    .TILES_DOWN   (TILES_DOWN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_start_i (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .job_push_o (job_push),
    .job_o      (push_job),
    .job_full_i (job_full)
  );

  pt2r_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (push_job),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job)
  );

  pt2r_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_i            (pop_job),
    .job_pop_o        (job_pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_index_o      (pix_index),
    .out_shade_o      (pix_shade),
    .out_row_done_o   (m_axis_tlast_o),
    .out_photo_done_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {pix_shade, pix_index};

endmodule

/* dv/pt2r_checker.sv */
`timescale 1ns / 1ps
// Pixel stream checker for the planar 2bpp tile to raster converter.
module pt2r_pixel_checker
  import pt2r_pkg::*;
#(
  parameter int unsigned TILES_ACROSS = TILES_ACROSS_DEF,
  parameter int unsigned TILES_DOWN   = TILES_DOWN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [BYTE_W-1:0]     s_data_i,    // [7:0] tile_byte
  input  logic                  s_user_i,    // [0] photo_start
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [OUT_DATA_W-1:0] m_data_i,    // [13:0] pixel_index, [15:14] shade
  input  logic                  m_last_i,    // row_done
  input  logic                  m_user_i,    // [0] photo_done
  output int                    errors_o,
  output int                    pending_o,
  output int                    pixels_o,
  output int                    photos_o
);

  localparam int unsigned PHOTO_TILES = TILES_ACROSS * TILES_DOWN;
  localparam int unsigned WIDTH_PX    = TILES_ACROSS * TILE_SIDE;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [SHADE_W-1:0] shade;
    logic               row_done;
    logic               photo_done;
  } pixel_t;

  // Pixels predicted but not yet seen on the output, oldest first
  pixel_t pixels_due[$];

  // Shadow of the converter state
  logic [BYTE_W-1:0] held_low;
  logic              want_high;
  logic [ROW_W-1:0]  row_in_tile;
  int unsigned       tile_idx;

  // Take one tile byte; a high-plane byte queues the eight pixels of its row
  task automatic take_tile_byte(input logic [BYTE_W-1:0] tbyte, input logic start);
    int unsigned col0;
    int unsigned row_px;
    logic        last_tile;
    pixel_t      px;
    if (start) begin
      tile_idx    = 0;
      row_in_tile = '0;
      want_high   = 1'b0;
    end
    if (!want_high) begin
      held_low  = tbyte;
      want_high = 1'b1;
      return;
    end
    col0      = (tile_idx % TILES_ACROSS) * TILE_SIDE;
    row_px    = (tile_idx / TILES_ACROSS) * TILE_SIDE + row_in_tile;
    last_tile = (tile_idx + 1 >= PHOTO_TILES) && (row_in_tile == 3'd7);
    for (int x = 0; x < TILE_SIDE; x++) begin
      px.index      = INDEX_W'(row_px * WIDTH_PX + col0 + x);
      px.shade      = 2'd3 - {tbyte[7-x], held_low[7-x]};
      px.row_done   = (x == 7);
      px.photo_done = (x == 7) && last_tile;
      pixels_due.push_back(px);
    end
    // Step to the next row, and the next tile after row 7
    want_high = 1'b0;
    if (row_in_tile == 3'd7) begin
      row_in_tile = '0;
      tile_idx++;
      if (tile_idx >= PHOTO_TILES) tile_idx = 0;
    end else begin
      row_in_tile++;
    end
  endtask

  // Watch both channels: predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      held_low    = '0;
      want_high   = 1'b0;
      row_in_tile = '0;
      tile_idx    = 0;
      pixels_due.delete();
      errors_o    = 0;
      pixels_o    = 0;
      photos_o    = 0;
    end else begin
      if (s_valid_i && s_ready_i) take_tile_byte(s_data_i, s_user_i);
      if (m_valid_i && m_ready_i) begin
        got.index      = m_data_i[INDEX_W-1:0];
        got.shade      = m_data_i[INDEX_W+SHADE_W-1:INDEX_W];
        got.row_done   = m_last_i;
        got.photo_done = m_user_i;
        pixels_o++;
        if (m_user_i) photos_o++;
        if (pixels_due.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected pixel: index=%0d shade=%0d row_done=%b photo_done=%b",
                   $time, got.index, got.shade, got.row_done, got.photo_done);
        end else begin
          want = pixels_due.pop_front();
          if (got.index !== want.index || got.shade !== want.shade ||
              got.row_done !== want.row_done || got.photo_done !== want.photo_done) begin
            errors_o++;
            $display("%0t: pixel mismatch: expected index=%0d shade=%0d row_done=%b %s%b",
                     $time, want.index, want.shade, want.row_done, "photo_done=",
                     want.photo_done);
            $display("%0t:                 actual   index=%0d shade=%0d row_done=%b %s%b",
                     $time, got.index, got.shade, got.row_done, "photo_done=",
                     got.photo_done);
          end
        end
      end
    end
    pending_o = pixels_due.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, tile byte stimulus, output pacing and verdict.
module testbench;
  import pt2r_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 20;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  s_valid = 1'b0;
  logic [BYTE_W-1:0]     s_data  = '0;
  logic                  s_user  = 1'b0;
  logic                  s_ready;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  m_last;
  logic                  m_user;

  // Pacing knobs, percent of cycles
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  // Long output hold-off, requested by toggling hold_req
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  int          bytes_sent  = 0;
  int          starts_sent = 0;
  int unsigned cycles      = 0;
  int          errors, pending, pixels, photos;

  // Opening bytes, {photo_start, tile_byte}: plane extremes, mixed patterns,
  // a full tile, start on a high-phase byte and start on a low-phase byte
  logic [8:0] opening_bytes [0:24] = '{
    9'h100, 9'h0FF,  9'h0FF, 9'h000,  9'h0FF, 9'h0FF,  9'h000, 9'h000,
    9'h0AA, 9'h055,  9'h055, 9'h0AA,  9'h081, 9'h07E,  9'h00F, 9'h03C,
    9'h0C3, 9'h0F0,  9'h012, 9'h134,  9'h056,  9'h09A, 9'h1BC, 9'h0DE,
    9'h100
  };

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  planar_2bpp_tile_to_raster #(
    .TILES_ACROSS (TILES_ACROSS_DEF),
    .TILES_DOWN   (TILES_DOWN_DEF)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  pt2r_pixel_checker #(
    .TILES_ACROSS (TILES_ACROSS_DEF),
    .TILES_DOWN   (TILES_DOWN_DEF)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_valid),
    .s_ready_i (s_ready),
    .s_data_i  (s_data),
    .s_user_i  (s_user),
    .m_valid_i (m_valid),
    .m_ready_i (m_ready),
    .m_data_i  (m_data),
    .m_last_i  (m_last),
    .m_user_i  (m_user),
    .errors_o  (errors),
    .pending_o (pending),
    .pixels_o  (pixels),
    .photos_o  (photos)
  );

  // Output side: random stalls, or a counted hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready   <= 1'b0;
      hold_left <= 0;
      hold_ack  <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pixels outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles first; returns after its transfer
  task automatic send_byte(input logic [BYTE_W-1:0] tbyte, input logic start);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= tbyte;
    s_user  <= start;
    do @(negedge clk_i); while (!s_ready);
    @(posedge clk_i);
    bytes_sent++;
    if (start) starts_sent++;
  endtask

  // Stop offering and wait until every predicted pixel has come out
  task automatic drain_pixels();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // One pacing phase of random bytes; start_odds of 0 means no random start flags
  task automatic run_phase(input int src_pct, input int snk_pct, input int count,
                           input int start_odds, input bit lead_start);
    logic start;
    src_idle_pct   = src_pct;
    snk_stall_pct <= snk_pct;
    for (int k = 0; k < count; k++) begin
      start = (k == 0 && lead_start) ||
              (start_odds != 0 && $urandom_range(start_odds - 1) == 0);
      send_byte(BYTE_W'($urandom_range(255)), start);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at full rate
    foreach (opening_bytes[i]) send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);

    // Hold the output off while bytes keep coming, so the input backs up
    hold_req <= ~hold_req;
    repeat (24) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
    drain_pixels();

    // An unbroken run across all pacing mixes, stepping over several tiles
    run_phase(0, 0, 40, 0, 1'b1);
    run_phase(49, 0, 35, 0, 1'b0);
    run_phase(0, 49, 35, 0, 1'b0);
    run_phase(8, 8, 30, 0, 1'b0);
    drain_pixels();

    // Random bytes with occasional start flags on either byte phase
    run_phase(0, 0, 20, 24, 1'b0);
    run_phase(49, 0, 20, 24, 1'b0);
    hold_req <= ~hold_req;
    run_phase(0, 49, 20, 24, 1'b0);
    run_phase(8, 8, 20, 24, 1'b0);

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d tile bytes (%0d with the start flag) over four pacing mixes %s",
             bytes_sent, starts_sent, "and two long output hold-offs.");
    $display("Checked %0d pixels, %0d of them closing a photo.", pixels, photos);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d pixels never seen", errors, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
design/pt2r_pkg.sv
design/pt2r_front.sv
design/pt2r_fifo.sv
design/pt2r_back.sv
design/planar_2bpp_tile_to_raster.sv
dv/pt2r_checker.sv
dv/testbench.sv
